/* rtl/obb_pkg.sv */
// Package for the oriented box to axis-aligned box block.
// Holds beat types, fixed-point widths, register indexes and helper functions.
// Depends on nothing.
package obb_pkg;

    localparam int QuatW  = 16;
    localparam int CoordW = 32;
    localparam int CoefW  = 30;   // clamped matrix entry, Q.28 in [-1, +1]
    localparam int MagW   = 29;   // magnitude of a matrix entry
    localparam int HalfW  = 31;
    localparam int CfgIdxW = 3;
    localparam int RawW   = 35;   // unclamped matrix entry

    localparam logic signed [RawW-1:0] OneQ28 = RawW'(64'sd1 <<< 28);

    typedef enum logic [CfgIdxW-1:0] {
        REG_CENTER_X      = 3'd0,
        REG_CENTER_Y      = 3'd1,
        REG_CENTER_Z      = 3'd2,
        REG_HALF_EXTENT_X = 3'd3,
        REG_HALF_EXTENT_Y = 3'd4,
        REG_HALF_EXTENT_Z = 3'd5
    } cfg_reg_t;

    typedef logic signed [CoefW-1:0]  coef_t;
    typedef logic        [MagW-1:0]   mag_t;
    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic        [HalfW-1:0]  half_t;

    typedef struct packed {
        logic signed [QuatW-1:0]  rot_w;
        logic signed [QuatW-1:0]  rot_x;
        logic signed [QuatW-1:0]  rot_y;
        logic signed [QuatW-1:0]  rot_z;
        logic signed [CoordW-1:0] pos_x;
        logic signed [CoordW-1:0] pos_y;
        logic signed [CoordW-1:0] pos_z;
    } in_beat_t;

    typedef struct packed {
        logic signed [CoordW-1:0] lo_x;
        logic signed [CoordW-1:0] lo_y;
        logic signed [CoordW-1:0] lo_z;
        logic signed [CoordW-1:0] hi_x;
        logic signed [CoordW-1:0] hi_y;
        logic signed [CoordW-1:0] hi_z;
    } out_beat_t;

    typedef struct packed {
        coord_t pos_x;
        coord_t pos_y;
        coord_t pos_z;
    } pos_t;

    function automatic coef_t clamp_one(input logic signed [RawW-1:0] v);
        coef_t r;
        if (v > OneQ28)
            r = CoefW'(OneQ28);
        else if (v < -OneQ28)
            r = CoefW'(-OneQ28);
        else
            r = v[CoefW-1:0];
        return r;
    endfunction

    function automatic mag_t mag_of(input coef_t v);
        coef_t n;
        n = -v;
        return v[CoefW-1] ? n[MagW-1:0] : v[MagW-1:0];
    endfunction

endpackage

/* rtl/obb_matrix.sv */
// Quaternion to clamped rotation matrix, two pipeline stages.
// Depends on obb_pkg.
module obb_matrix (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  obb_pkg::in_beat_t up_data,
    output logic              dn_valid,
    input  logic              dn_ready,
    output obb_pkg::coef_t    dn_coef [9],
    output obb_pkg::mag_t     dn_mag [9],
    output obb_pkg::pos_t     dn_pos
);
    import obb_pkg::*;

    logic               a_valid_reg, b_valid_reg;
    logic signed [31:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [31:0] wx_reg, wy_reg, wz_reg;
    pos_t               a_pos_reg, b_pos_reg;
    coef_t              coef_next [9];
    coef_t              coef_reg [9];
    mag_t               mag_reg [9];
    logic               en_a, en_b;

    assign en_b     = !b_valid_reg || dn_ready;
    assign en_a     = !a_valid_reg || en_b;
    assign up_ready = en_a;

    function automatic logic signed [RawW-1:0] ext(input logic signed [31:0] v);
        return RawW'(v);
    endfunction

    always_comb
    begin
        coef_next[0] = clamp_one(OneQ28 - 2 * (ext(yy_reg) + ext(zz_reg)));
        coef_next[1] = clamp_one(2 * (ext(xy_reg) - ext(wz_reg)));
        coef_next[2] = clamp_one(2 * (ext(xz_reg) + ext(wy_reg)));
        coef_next[3] = clamp_one(2 * (ext(xy_reg) + ext(wz_reg)));
        coef_next[4] = clamp_one(OneQ28 - 2 * (ext(xx_reg) + ext(zz_reg)));
        coef_next[5] = clamp_one(2 * (ext(yz_reg) - ext(wx_reg)));
        coef_next[6] = clamp_one(2 * (ext(xz_reg) - ext(wy_reg)));
        coef_next[7] = clamp_one(2 * (ext(yz_reg) + ext(wx_reg)));
        coef_next[8] = clamp_one(OneQ28 - 2 * (ext(xx_reg) + ext(yy_reg)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
                a_valid_reg <= up_valid;
            if (en_b)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a && up_valid)
        begin
            xx_reg    <= up_data.rot_x * up_data.rot_x;
            yy_reg    <= up_data.rot_y * up_data.rot_y;
            zz_reg    <= up_data.rot_z * up_data.rot_z;
            xy_reg    <= up_data.rot_x * up_data.rot_y;
            xz_reg    <= up_data.rot_x * up_data.rot_z;
            yz_reg    <= up_data.rot_y * up_data.rot_z;
            wx_reg    <= up_data.rot_w * up_data.rot_x;
            wy_reg    <= up_data.rot_w * up_data.rot_y;
            wz_reg    <= up_data.rot_w * up_data.rot_z;
            a_pos_reg <= '{up_data.pos_x, up_data.pos_y, up_data.pos_z};
        end
        if (en_b && a_valid_reg)
        begin
            for (int i = 0; i < 9; i++)
            begin
                coef_reg[i] <= coef_next[i];
                mag_reg[i]  <= mag_of(coef_next[i]);
            end
            b_pos_reg <= a_pos_reg;
        end
    end

    assign dn_valid = b_valid_reg;
    assign dn_coef  = coef_reg;
    assign dn_mag   = mag_reg;
    assign dn_pos   = b_pos_reg;
endmodule

/* rtl/obb_extent.sv */
// Centre projection and extent projection: products, then row sums.
// Depends on obb_pkg.
module obb_extent (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  obb_pkg::coef_t    up_coef [9],
    input  obb_pkg::mag_t     up_mag [9],
    input  obb_pkg::pos_t     up_pos,
    input  obb_pkg::coord_t   center [3],
    input  obb_pkg::half_t    half [3],
    output logic              dn_valid,
    input  logic              dn_ready,
    output logic signed [63:0] dn_mid [3],
    output logic signed [63:0] dn_span [3],
    output obb_pkg::pos_t     dn_pos
);
    import obb_pkg::*;

    // Over the eight corners the extreme of a row is the centre term plus or
    // minus the sum of |m| times the half extents, so only these are needed.
    logic               a_valid_reg, b_valid_reg;
    logic signed [61:0] cp_reg [9];
    logic        [59:0] hp_reg [9];
    logic signed [63:0] mid_reg [3];
    logic signed [63:0] span_reg [3];
    pos_t               a_pos_reg, b_pos_reg;
    logic               en_a, en_b;

    assign en_b     = !b_valid_reg || dn_ready;
    assign en_a     = !a_valid_reg || en_b;
    assign up_ready = en_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
                a_valid_reg <= up_valid;
            if (en_b)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a && up_valid)
        begin
            for (int i = 0; i < 9; i++)
            begin
                cp_reg[i] <= 62'(up_coef[i]) * 62'(center[i % 3]);
                hp_reg[i] <= 60'(up_mag[i]) * 60'(half[i % 3]);
            end
            a_pos_reg <= up_pos;
        end
        if (en_b && a_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                mid_reg[r]  <= 64'(cp_reg[3*r]) + 64'(cp_reg[3*r+1]) + 64'(cp_reg[3*r+2]);
                span_reg[r] <= $signed({4'b0, hp_reg[3*r]}) + $signed({4'b0, hp_reg[3*r+1]})
                             + $signed({4'b0, hp_reg[3*r+2]});
            end
            b_pos_reg <= a_pos_reg;
        end
    end

    assign dn_valid = b_valid_reg;
    assign dn_mid   = mid_reg;
    assign dn_span  = span_reg;
    assign dn_pos   = b_pos_reg;
endmodule

/* rtl/obb_output.sv */
// Rounding to Q16.16, position offset and saturation, two stages.
// Depends on obb_pkg.
module obb_output (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  logic signed [63:0] up_mid [3],
    input  logic signed [63:0] up_span [3],
    input  obb_pkg::pos_t      up_pos,
    output logic               dn_valid,
    input  logic               dn_ready,
    output obb_pkg::out_beat_t dn_data
);
    import obb_pkg::*;

    localparam logic signed [63:0] Half = 64'sd1 <<< 27;
    localparam logic signed [36:0] SatHi = 37'sd2147483647;
    localparam logic signed [36:0] SatLo = -37'sd2147483648;

    logic               a_valid_reg, b_valid_reg;
    logic signed [35:0] lo_reg [3];
    logic signed [35:0] hi_reg [3];
    pos_t               a_pos_reg;
    out_beat_t          out_reg;
    logic signed [63:0] lo_t [3];
    logic signed [63:0] hi_t [3];
    coord_t             pos_a [3];
    coord_t             lo_s [3];
    coord_t             hi_s [3];
    logic               en_a, en_b;

    assign en_b     = !b_valid_reg || dn_ready;
    assign en_a     = !a_valid_reg || en_b;
    assign up_ready = en_a;

    function automatic coord_t sat(input logic signed [35:0] v, input coord_t p);
        logic signed [36:0] s;
        s = 37'(v) + 37'(p);
        if (s > SatHi)
            return SatHi[31:0];
        else if (s < SatLo)
            return SatLo[31:0];
        return s[31:0];
    endfunction

    assign pos_a[0] = a_pos_reg.pos_x;
    assign pos_a[1] = a_pos_reg.pos_y;
    assign pos_a[2] = a_pos_reg.pos_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lo_t[i] = up_mid[i] - up_span[i] + Half;
            hi_t[i] = up_mid[i] + up_span[i] + Half;
            lo_s[i] = sat(lo_reg[i], pos_a[i]);
            hi_s[i] = sat(hi_reg[i], pos_a[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
                a_valid_reg <= up_valid;
            if (en_b)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a && up_valid)
        begin
            // An arithmetic shift is the floor, giving round half up.
            for (int i = 0; i < 3; i++)
            begin
                lo_reg[i] <= lo_t[i][63:28];
                hi_reg[i] <= hi_t[i][63:28];
            end
            a_pos_reg <= up_pos;
        end
        if (en_b && a_valid_reg)
            out_reg <= '{lo_s[0], lo_s[1], lo_s[2], hi_s[0], hi_s[1], hi_s[2]};
    end

    assign dn_valid = b_valid_reg;
    assign dn_data  = out_reg;
endmodule

/* rtl/oriented_box_to_aabb_top.sv */
// Top level of the oriented box to axis-aligned box block.
// Depends on obb_pkg, obb_matrix, obb_extent and obb_output.
//
// One beat in gives one beat out; a new beat may enter in every cycle, and a
// stalled pipeline fills its empty stages before it stops taking input. Its six
// register stages: quaternion products, matrix entries, matrix by box products,
// row sums, rounding, and position offset with saturation. Configuration is
// written through cfg_we, cfg_index and cfg_data; the user must write it only
// while no beat is in flight (not enforced). Unknown indexes are ignored.
module oriented_box_to_aabb_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  obb_pkg::in_beat_t               in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output obb_pkg::out_beat_t              out_data,
    input  logic                            cfg_we,
    input  logic [obb_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [obb_pkg::CoordW-1:0]      cfg_data
);
    import obb_pkg::*;

    coord_t             center_reg [3];
    half_t              half_reg [3];
    logic               m_valid, m_ready, e_valid, e_ready;
    coef_t              m_coef [9];
    mag_t               m_mag [9];
    pos_t               m_pos, e_pos;
    logic signed [63:0] e_mid [3];
    logic signed [63:0] e_span [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                center_reg[i] <= '0;
                half_reg[i]   <= HalfW'(65536);
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CENTER_X:      center_reg[0] <= cfg_data;
                REG_CENTER_Y:      center_reg[1] <= cfg_data;
                REG_CENTER_Z:      center_reg[2] <= cfg_data;
                REG_HALF_EXTENT_X: half_reg[0]   <= cfg_data[HalfW-1:0];
                REG_HALF_EXTENT_Y: half_reg[1]   <= cfg_data[HalfW-1:0];
                REG_HALF_EXTENT_Z: half_reg[2]   <= cfg_data[HalfW-1:0];
                default: ;
            endcase
        end
    end

    obb_matrix u_matrix (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_ready (in_ready),
        .up_data  (in_data),
        .dn_valid (m_valid),
        .dn_ready (m_ready),
        .dn_coef  (m_coef),
        .dn_mag   (m_mag),
        .dn_pos   (m_pos)
    );

    obb_extent u_extent (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (m_valid),
        .up_ready (m_ready),
        .up_coef  (m_coef),
        .up_mag   (m_mag),
        .up_pos   (m_pos),
        .center   (center_reg),
        .half     (half_reg),
        .dn_valid (e_valid),
        .dn_ready (e_ready),
        .dn_mid   (e_mid),
        .dn_span  (e_span),
        .dn_pos   (e_pos)
    );

    obb_output u_output (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (e_valid),
        .up_ready (e_ready),
        .up_mid   (e_mid),
        .up_span  (e_span),
        .up_pos   (e_pos),
        .dn_valid (out_valid),
        .dn_ready (out_ready),
        .dn_data  (out_data)
    );
endmodule

/* rtl/obb_checker.sv */
// Port-level checker for the oriented box to axis-aligned box block, and its bind.
// Depends on obb_pkg and oriented_box_to_aabb_top.
module obb_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input obb_pkg::out_beat_t out_data
);
    import obb_pkg::*;

    // A result beat waiting to be taken stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // With the output stage free to move, the whole pipeline can take a beat.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input stalled while the pipeline could advance");

    // The minimum never exceeds the maximum on any axis.
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.lo_x <= out_data.hi_x && out_data.lo_y <= out_data.hi_y
                   && out_data.lo_z <= out_data.hi_z)
        else $error("box minimum above maximum");
endmodule

bind oriented_box_to_aabb_top obb_checker u_obb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
